// File: rtl/tlb_page_translation_defines.svh
// ----------------------------------------------------------------------------
// tlb_page_translation assertion macros
// shared concurrent assertion forms used by the translation block modules
// ----------------------------------------------------------------------------
`ifndef TLB_PAGE_TRANSLATION_DEFINES_SVH
`define TLB_PAGE_TRANSLATION_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TPT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TPT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/tpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpt_pkg
// types and constants shared by the page translation block
// ----------------------------------------------------------------------------
package tpt_pkg;

    // fixed field widths of the transfer payloads
    localparam int VADDR_W  = 22;
    localparam int PAGE_W   = 10;
    localparam int PHYS_W   = 22;
    localparam int ASSIGN_W = 10;

    // default geometry
    localparam int VPN_BITS_DEF     = 10;
    localparam int OFFSET_WIDTH_DEF = 12;
    localparam int TLB_ENTRIES_DEF  = 16;
    localparam int FRAME_BITS_DEF   = 10;

    typedef enum logic {
        CMD_TRANSLATE = 1'b0,
        CMD_MAP       = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd                cmd;
        logic [VADDR_W-1:0]  virt_addr;
        logic [PAGE_W-1:0]   page_number;
    } t_item;

    typedef struct packed {
        logic [PHYS_W-1:0]   phys_addr;
        logic                fault;
        logic                tlb_hit;
        logic [ASSIGN_W-1:0] assigned_frame;
    } t_result;

endpackage

// File: rtl/tpt_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpt_table
// page table memory with per-entry valid bit, clear pass and free-frame counter
// ----------------------------------------------------------------------------
`include "tlb_page_translation_defines.svh"

module tpt_table #(
    parameter int VPN_BITS   = tpt_pkg::VPN_BITS_DEF,
    parameter int FRAME_BITS = tpt_pkg::FRAME_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr,
    input  logic                  i_rd,
    input  logic [VPN_BITS-1:0]   i_page,
    output logic                  o_busy,
    output logic [FRAME_BITS-1:0] o_free,
    output logic                  o_rd_valid,
    output logic [FRAME_BITS-1:0] o_rd_frame
);

    localparam int PAGE_COUNT = 1 << VPN_BITS;

    // valid bit above the frame number
    logic [FRAME_BITS:0]   r_mem [PAGE_COUNT];
    logic [FRAME_BITS:0]   r_rd;
    logic                  r_clearing;
    logic [VPN_BITS-1:0]   r_clr_addr;
    logic [FRAME_BITS-1:0] r_free;

    logic                  w_we;
    logic [VPN_BITS-1:0]   w_waddr;
    logic [FRAME_BITS:0]   w_wdata;

    always_comb begin
        w_we    = r_clearing | i_wr;
        w_waddr = r_clearing ? r_clr_addr : i_page;
        w_wdata = r_clearing ? '0 : {1'b1, r_free};
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_rd) begin
            r_rd <= r_mem[i_page];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_free     <= '0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    r_clearing <= 1'b0;
                end
            end
            if (i_wr) begin
                r_free <= r_free + 1'b1;
            end
        end
    end

    assign o_busy     = r_clearing;
    assign o_free     = r_free;
    assign o_rd_valid = r_rd[FRAME_BITS];
    assign o_rd_frame = r_rd[FRAME_BITS-1:0];

    `TPT_ASSERT_IMP(a_no_map_in_clear, i_clk, i_rst_n, r_clearing, !i_wr, "map during clear pass")
    `TPT_ASSERT_NXT(a_clear_ends, i_clk, i_rst_n, r_clearing && (r_clr_addr == '1), !r_clearing, "clear pass did not end")
    `TPT_ASSERT_NXT(a_free_holds, i_clk, i_rst_n, !i_wr, $stable(r_free), "free frame moved without a map")

endmodule

// File: rtl/tpt_tlb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpt_tlb
// fully associative translation cache with fifo replacement
// ----------------------------------------------------------------------------
`include "tlb_page_translation_defines.svh"

module tpt_tlb #(
    parameter int VPN_BITS    = tpt_pkg::VPN_BITS_DEF,
    parameter int FRAME_BITS  = tpt_pkg::FRAME_BITS_DEF,
    parameter int TLB_ENTRIES = tpt_pkg::TLB_ENTRIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_lookup,
    input  logic [VPN_BITS-1:0]   i_page,
    input  logic                  i_fill_ok,
    input  logic [FRAME_BITS-1:0] i_fill_frame,
    output logic                  o_hit,
    output logic [FRAME_BITS-1:0] o_frame
);

    localparam int IDX_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

    logic [VPN_BITS-1:0]   r_page  [TLB_ENTRIES];
    logic [FRAME_BITS-1:0] r_frame [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] r_valid;
    logic [IDX_W-1:0]      r_oldest;

    logic [TLB_ENTRIES-1:0] w_match;
    logic                  w_fill;

    always_comb begin
        o_frame = '0;
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            w_match[i] = r_valid[i] && (r_page[i] == i_page);
        end
        // lowest matching slot wins
        for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                o_frame = r_frame[i];
            end
        end
        o_hit  = |w_match;
        w_fill = i_lookup && !o_hit && i_fill_ok;
    end

    always_ff @(posedge i_clk) begin
        if (w_fill) begin
            r_page[r_oldest]  <= i_page;
            r_frame[r_oldest] <= i_fill_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_oldest <= '0;
        end else if (w_fill) begin
            r_valid[r_oldest] <= 1'b1;
            if (r_oldest == IDX_W'(TLB_ENTRIES - 1)) begin
                r_oldest <= '0;
            end else begin
                r_oldest <= r_oldest + 1'b1;
            end
        end
    end

    `TPT_ASSERT_IMP(a_single_match, i_clk, i_rst_n, i_lookup, $onehot0(w_match), "page held in two slots")
    `TPT_ASSERT_NXT(a_fifo_holds, i_clk, i_rst_n, !w_fill, $stable(r_oldest), "fifo pointer moved without a fill")

endmodule

// File: rtl/tlb_page_translation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_page_translation
// page mapping and virtual-to-physical translation through a tlb and page table
// ----------------------------------------------------------------------------
// commands come in on i_item and are taken at a clock edge where start is
// high and busy is low. a map command hands the next free frame to a page;
// a translate command looks up the page in the tlb, then in the page table,
// and loads the tlb on a table hit.
// each command gives one result on o_result, marked by o_strobe for one
// cycle. a taken command passes through the stage-one registers and then
// the result register; one command can be taken every cycle while busy
// is low; the page table memory is read at the accept edge and the tlb
// search and fill happen in the following cycle. after reset busy stays
// high while the page table valid bits are cleared one entry per cycle;
// the tlb and frame counter are empty right away. results cannot be held
// off by the receiver, so o_strobe only follows the registered accept.
// ----------------------------------------------------------------------------
`include "tlb_page_translation_defines.svh"

module tlb_page_translation #(
    parameter int VPN_BITS     = tpt_pkg::VPN_BITS_DEF,
    parameter int OFFSET_WIDTH = tpt_pkg::OFFSET_WIDTH_DEF,
    parameter int TLB_ENTRIES  = tpt_pkg::TLB_ENTRIES_DEF,
    parameter int FRAME_BITS   = tpt_pkg::FRAME_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  tpt_pkg::t_item   i_item,
    output logic             o_strobe,
    output tpt_pkg::t_result o_result
);

    localparam int PHYS_W   = tpt_pkg::PHYS_W;
    localparam int ASSIGN_W = tpt_pkg::ASSIGN_W;

    logic                    w_accept;
    logic                    w_is_map;
    logic [VPN_BITS-1:0]     w_va_page;
    logic [VPN_BITS-1:0]     w_acc_page;
    logic [FRAME_BITS-1:0]   w_free;
    logic                    w_tbl_valid;
    logic [FRAME_BITS-1:0]   w_tbl_frame;
    logic                    w_lookup;
    logic                    w_hit;
    logic [FRAME_BITS-1:0]   w_hit_frame;
    logic [FRAME_BITS-1:0]   w_frame;
    logic                    w_fault;
    logic [FRAME_BITS+OFFSET_WIDTH-1:0] w_pa_wide;
    tpt_pkg::t_result        n_result;

    // stage one: item after the accept edge
    logic                    r_s1_valid;
    tpt_pkg::t_cmd           r_s1_cmd;
    logic [VPN_BITS-1:0]     r_s1_page;
    logic [OFFSET_WIDTH-1:0] r_s1_off;
    logic [FRAME_BITS-1:0]   r_s1_assigned;
    tpt_pkg::t_result        r_result;
    logic                    r_strobe;

    assign w_accept   = start && !busy;
    assign w_is_map   = (i_item.cmd == tpt_pkg::CMD_MAP);
    assign w_va_page  = VPN_BITS'(i_item.virt_addr >> OFFSET_WIDTH);
    assign w_acc_page = w_is_map ? VPN_BITS'(i_item.page_number) : w_va_page;

    tpt_table #(
        .VPN_BITS   (VPN_BITS),
        .FRAME_BITS (FRAME_BITS)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (w_accept && w_is_map),
        .i_rd       (w_accept && !w_is_map),
        .i_page     (w_acc_page),
        .o_busy     (busy),
        .o_free     (w_free),
        .o_rd_valid (w_tbl_valid),
        .o_rd_frame (w_tbl_frame)
    );

    assign w_lookup = r_s1_valid && (r_s1_cmd == tpt_pkg::CMD_TRANSLATE);

    tpt_tlb #(
        .VPN_BITS    (VPN_BITS),
        .FRAME_BITS  (FRAME_BITS),
        .TLB_ENTRIES (TLB_ENTRIES)
    ) u_tlb (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_lookup     (w_lookup),
        .i_page       (r_s1_page),
        .i_fill_ok    (w_tbl_valid),
        .i_fill_frame (w_tbl_frame),
        .o_hit        (w_hit),
        .o_frame      (w_hit_frame)
    );

    always_comb begin
        w_frame   = w_hit ? w_hit_frame : w_tbl_frame;
        w_fault   = !w_hit && !w_tbl_valid;
        w_pa_wide = {w_frame, r_s1_off};
        n_result  = '0;
        if (r_s1_cmd == tpt_pkg::CMD_MAP) begin
            n_result.assigned_frame = ASSIGN_W'(r_s1_assigned);
        end else begin
            n_result.tlb_hit = w_hit;
            n_result.fault   = w_fault;
            if (!w_fault) begin
                n_result.phys_addr = PHYS_W'(w_pa_wide);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_cmd      <= i_item.cmd;
            r_s1_page     <= w_va_page;
            r_s1_off      <= OFFSET_WIDTH'(i_item.virt_addr);
            r_s1_assigned <= w_free;
        end
        if (r_s1_valid) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
            r_strobe   <= r_s1_valid;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    `TPT_ASSERT_NXT(a_result_follows, i_clk, i_rst_n, r_s1_valid, o_strobe, "stage item produced no result")
    `TPT_ASSERT_IMP(a_hit_not_fault, i_clk, i_rst_n, o_strobe, !(o_result.fault && o_result.tlb_hit), "fault flagged on a tlb hit")
    `TPT_ASSERT_IMP(a_fault_zero, i_clk, i_rst_n, o_strobe && o_result.fault, o_result.phys_addr == '0, "fault with nonzero address")

endmodule
